// ----- rtl/bitmap_page_allocator_assert.svh -----
// Assertion macros used by the checker file of the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

   localparam int TOTAL_PAGES    = 4096;
   localparam int PAGE_BYTES     = 4096;
   localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
   localparam int RESERVED_PAGES = 512;

   localparam int ADDR_W   = 24;
   localparam int COUNT_W  = 13;
   localparam int STATUS_W = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_DONE = 2'd0;
   localparam status_type STATUS_OOM  = 2'd1;
   localparam status_type STATUS_NULL = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [7:0] BYTE_FULL = 8'hFF;

endpackage

`default_nettype wire

// ----- rtl/bpa_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request channel: allocate or free one page.
interface bpa_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [bpa_pkg::ADDR_W-1:0] free_address;

   modport source (output valid, req_type, free_address, input ready);
   modport sink   (input valid, req_type, free_address, output ready);
   modport mon    (input valid, ready, req_type, free_address);
endinterface

// Response channel: one result per request.
interface bpa_rsp_if;
   logic                        valid;
   logic                        ready;
   bpa_pkg::status_type         status;
   logic [bpa_pkg::ADDR_W-1:0]  page_address;
   logic [bpa_pkg::COUNT_W-1:0] free_page_count;
   logic [bpa_pkg::COUNT_W-1:0] used_page_count;

   modport source (output valid, status, page_address, free_page_count, used_page_count,
                   input ready);
   modport sink   (input valid, status, page_address, free_page_count, used_page_count,
                   output ready);
   modport mon    (input valid, ready, status, page_address, free_page_count,
                   used_page_count);
endinterface

`default_nettype wire

// ----- rtl/bpa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bitmap_page_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bitmap first-fit page allocator.
// Requests arrive on req_ch: req_type selects allocate or free, and free_address names
// the page to release (offset bits inside the page are ignored, zero is a no-op).
// Every request gives exactly one transfer on rsp_ch with a status, the allocated page
// address and the free and used page counts after the request.
// The used/free bitmap lives in one RAM, one byte (eight pages) per entry. An allocate
// reads one byte per cycle from the bottom and stops at the first byte that is not
// full, then sets its lowest clear bit and responds. A free of a page in the bitmap
// reads its byte, clears the bit and then responds.
// The RAM read port, one byte per cycle, sets the allocate time.
// After reset the block writes the reset image into the bitmap, one byte per cycle;
// req_ch.ready stays low until every byte is written.
// The low reserved pages come out of reset marked used, all others free.
// The response sits in an output register. A new request is accepted while it waits;
// that request finishes its work and then holds until rsp_ch takes the older result.
module bitmap_page_allocator #(
   parameter int TOTAL_PAGES = bpa_pkg::TOTAL_PAGES
) (
   input wire logic clock,
   input wire logic reset,
   bpa_req_if.sink  req_ch,
   bpa_rsp_if.source rsp_ch
);

   localparam int BYTES   = (TOTAL_PAGES + 7) / 8;
   localparam int BA_W    = $clog2(BYTES);
   localparam int CNT_W   = $clog2(TOTAL_PAGES + 1);
   localparam int RES     = (bpa_pkg::RESERVED_PAGES > TOTAL_PAGES) ?
                            TOTAL_PAGES : bpa_pkg::RESERVED_PAGES;
   localparam int PG_W    = bpa_pkg::ADDR_W - bpa_pkg::PAGE_SHIFT;

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_FREE = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [BA_W-1:0]              init_ptr_ff, init_ptr_in;
   logic [BA_W:0]                ptr_ff, ptr_in;
   logic [BA_W-1:0]              chk_ptr_ff, chk_ptr_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [BA_W-1:0]              fbyte_ff, fbyte_in;
   logic [2:0]                   fbit_ff, fbit_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   bpa_pkg::status_type          pend_status_ff, pend_status_in;
   logic [bpa_pkg::ADDR_W-1:0]   pend_addr_ff, pend_addr_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   bpa_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [bpa_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [bpa_pkg::COUNT_W-1:0]  rsp_free_ff, rsp_free_in;
   logic [bpa_pkg::COUNT_W-1:0]  rsp_used_ff, rsp_used_in;

   logic                         wr_en;
   logic [BA_W-1:0]              wr_addr;
   logic [7:0]                   wr_data;
   logic                         rd_en;
   logic [BA_W-1:0]              rd_addr;
   logic [7:0]                   rd_data;

   logic                         accept;
   logic [7:0]                   init_byte;
   logic [31:0]                  init_lo;
   logic [2:0]                   zbit;
   logic [31:0]                  scan_page;
   logic [PG_W-1:0]              free_page;
   logic [31:0]                  free_byte;
   logic [31:0]                  used_wide;

   bpa_ram #(
      .WIDTH (8),
      .DEPTH (BYTES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // Reset image of one bitmap byte: all ones below the reserved boundary, a partial
   // mask in the byte that straddles it, zero above.
   always_comb begin
      init_lo = 32'(init_ptr_ff) << 3;
      if (init_lo + 32'd8 <= 32'(RES)) begin
         init_byte = bpa_pkg::BYTE_FULL;
      end else if (init_lo >= 32'(RES)) begin
         init_byte = 8'h00;
      end else begin
         init_byte = 8'((9'd1 << 4'(32'(RES) - init_lo)) - 9'd1);
      end
   end

   // Lowest clear bit of the byte under test.
   always_comb begin
      zbit = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!rd_data[i]) begin
            zbit = 3'(i);
         end
      end
   end

   assign scan_page = {{(32 - BA_W - 3){1'b0}}, chk_ptr_ff, zbit};
   assign free_page = req_ch.free_address[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
   assign free_byte = 32'(free_page) >> 3;
   assign used_wide = 32'(TOTAL_PAGES) - 32'(cnt_ff);

   always_comb begin
      state_in       = state_ff;
      init_ptr_in    = init_ptr_ff;
      ptr_in         = ptr_ff;
      chk_ptr_in     = chk_ptr_ff;
      chk_vld_in     = 1'b0;
      fbyte_in       = fbyte_ff;
      fbit_in        = fbit_ff;
      cnt_in         = cnt_ff;
      pend_status_in = pend_status_ff;
      pend_addr_in   = pend_addr_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_used_in    = rsp_used_ff;

      wr_en   = 1'b0;
      wr_addr = init_ptr_ff;
      wr_data = init_byte;
      rd_en   = 1'b0;
      rd_addr = ptr_ff[BA_W-1:0];

      case (state_ff)
         S_INIT: begin
            wr_en       = 1'b1;
            init_ptr_in = init_ptr_ff + 1'b1;
            if (32'(init_ptr_ff) == 32'(BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               pend_status_in = bpa_pkg::STATUS_DONE;
               pend_addr_in   = '0;
               if (req_ch.req_type == bpa_pkg::REQ_ALLOC) begin
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end else if (req_ch.free_address == '0) begin
                  pend_status_in = bpa_pkg::STATUS_NULL;
                  state_in       = S_DONE;
               end else if (32'(free_page) >= 32'(TOTAL_PAGES)) begin
                  // Page beyond the end of the bitmap: nothing to clear.
                  state_in = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = free_byte[BA_W-1:0];
                  fbyte_in = free_byte[BA_W-1:0];
                  fbit_in  = free_page[2:0];
                  state_in = S_FREE;
               end
            end
         end

         S_SCAN: begin
            // Keep one read in flight; the byte fetched last cycle is tested now.
            if (32'(ptr_ff) < 32'(BYTES)) begin
               rd_en      = 1'b1;
               ptr_in     = ptr_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_ptr_in = ptr_ff[BA_W-1:0];
            end
            if (chk_vld_ff) begin
               if (rd_data != bpa_pkg::BYTE_FULL) begin
                  state_in = S_DONE;
                  if (scan_page >= 32'(TOTAL_PAGES)) begin
                     pend_status_in = bpa_pkg::STATUS_OOM;
                  end else begin
                     wr_en        = 1'b1;
                     wr_addr      = chk_ptr_ff;
                     wr_data      = rd_data | (8'd1 << zbit);
                     pend_addr_in = 24'(scan_page << bpa_pkg::PAGE_SHIFT);
                     if (cnt_ff != '0) begin
                        cnt_in = cnt_ff - 1'b1;
                     end
                  end
               end else if (32'(chk_ptr_ff) == 32'(BYTES - 1)) begin
                  pend_status_in = bpa_pkg::STATUS_OOM;
                  state_in       = S_DONE;
               end
            end
         end

         S_FREE: begin
            // Only a set bit counts; a double free leaves state untouched.
            if (rd_data[fbit_ff]) begin
               wr_en   = 1'b1;
               wr_addr = fbyte_ff;
               wr_data = rd_data & ~(8'd1 << fbit_ff);
               cnt_in  = cnt_ff + 1'b1;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_addr_in   = pend_addr_ff;
               rsp_free_in   = bpa_pkg::COUNT_W'(32'(cnt_ff));
               rsp_used_in   = used_wide[bpa_pkg::COUNT_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ptr_ff  <= '0;
         chk_vld_ff   <= 1'b0;
         cnt_ff       <= CNT_W'(TOTAL_PAGES - RES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ptr_ff  <= init_ptr_in;
         chk_vld_ff   <= chk_vld_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      chk_ptr_ff     <= chk_ptr_in;
      fbyte_ff       <= fbyte_in;
      fbit_ff        <= fbit_in;
      pend_status_ff <= pend_status_in;
      pend_addr_ff   <= pend_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.page_address    = rsp_addr_ff;
   assign rsp_ch.free_page_count = rsp_free_ff;
   assign rsp_ch.used_page_count = rsp_used_ff;

endmodule

`default_nettype wire

// ----- rtl/bpa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_page_allocator_assert.svh"

module bpa_checker #(
   parameter int TOTAL_PAGES = bpa_pkg::TOTAL_PAGES
) (
   input wire logic  clock,
   input wire logic  reset,
   bpa_req_if.sink   req_ch,
   bpa_rsp_if.source rsp_ch
);

   localparam logic [bpa_pkg::COUNT_W-1:0] TOTAL_MOD = bpa_pkg::COUNT_W'(TOTAL_PAGES);

   // A stalled response must stay offered.
   `BPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid, "response dropped while stalled")

   // Free and used counts always add up to the number of pages.
   `BPA_ASSERT_IMPL(a_count_sum, clock, reset, rsp_ch.valid, bpa_pkg::COUNT_W'(rsp_ch.free_page_count + rsp_ch.used_page_count) == TOTAL_MOD, "free and used counts disagree")

   // Addresses are page aligned and only a completed request carries one.
   `BPA_ASSERT_IMPL(a_addr_shape, clock, reset, rsp_ch.valid, rsp_ch.page_address[bpa_pkg::PAGE_SHIFT-1:0] == '0 && (rsp_ch.status == bpa_pkg::STATUS_DONE || rsp_ch.page_address == '0), "bad page address in response")

   // Input ready is low when reset falls, as the bitmap initialization starts.
   `BPA_ASSERT_IMPL(a_init_busy, clock, reset, $fell(reset), !req_ch.ready, "request taken during bitmap initialization")

endmodule

bind bitmap_page_allocator bpa_checker #(
   .TOTAL_PAGES (TOTAL_PAGES)
) u_bpa_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);

`default_nettype wire

// ----- dv/page_allocator_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the page allocator, keeps its own copy of the used/free map
// and the free page count, and checks every response against the oldest prediction.
module page_allocator_checker (
   input  logic    clock,
   input  logic    reset,
   bpa_req_if.mon  req_ch,
   bpa_rsp_if.mon  rsp_ch,
   output int      mismatch_count,
   output int      results_pending
);

   localparam int MAP_BYTES = (bpa_pkg::TOTAL_PAGES + 7) / 8;

   typedef struct {
      bpa_pkg::status_type          status;
      logic [bpa_pkg::ADDR_W-1:0]   page_address;
      logic [bpa_pkg::COUNT_W-1:0]  free_count;
      logic [bpa_pkg::COUNT_W-1:0]  used_count;
   } page_result_type;

   logic [7:0]      used_map [MAP_BYTES];
   int              free_left;
   int              errors = 0;
   page_result_type predicted_results [$];

   // Applies one request to the shadow map and returns the response it must produce.
   function automatic page_result_type apply_request(input logic kind,
                                                     input logic [bpa_pkg::ADDR_W-1:0] addr);
      page_result_type r;
      int              page;
      int              byte_idx;
      int              bit_idx;
      r.status       = bpa_pkg::STATUS_DONE;
      r.page_address = '0;
      if (kind == bpa_pkg::REQ_ALLOC) begin
         // First fit: skip full bytes, then take the lowest clear bit.
         page     = bpa_pkg::TOTAL_PAGES;
         byte_idx = 0;
         while (page == bpa_pkg::TOTAL_PAGES && byte_idx < MAP_BYTES) begin
            if (used_map[byte_idx] != bpa_pkg::BYTE_FULL) begin
               bit_idx = 0;
               while (used_map[byte_idx][bit_idx]) bit_idx++;
               page = byte_idx * 8 + bit_idx;
            end
            byte_idx++;
         end
         if (page >= bpa_pkg::TOTAL_PAGES) begin
            r.status = bpa_pkg::STATUS_OOM;
         end else begin
            used_map[page >> 3][page & 7] = 1'b1;
            if (free_left > 0) free_left--;
            r.page_address = bpa_pkg::ADDR_W'(page * bpa_pkg::PAGE_BYTES);
         end
      end else if (addr == '0) begin
         r.status = bpa_pkg::STATUS_NULL;
      end else begin
         // A page that is already free is left alone, so the count cannot drift.
         page = int'(addr >> bpa_pkg::PAGE_SHIFT);
         if (page < bpa_pkg::TOTAL_PAGES && used_map[page >> 3][page & 7]) begin
            used_map[page >> 3][page & 7] = 1'b0;
            free_left++;
         end
      end
      r.free_count = bpa_pkg::COUNT_W'(free_left);
      r.used_count = bpa_pkg::COUNT_W'(bpa_pkg::TOTAL_PAGES - free_left);
      return r;
   endfunction

   always @(posedge clock) begin
      page_result_type want;
      if (reset) begin
         for (int i = 0; i < MAP_BYTES; i++) used_map[i] = 8'h00;
         for (int pg = 0; pg < bpa_pkg::RESERVED_PAGES && pg < bpa_pkg::TOTAL_PAGES; pg++)
            used_map[pg >> 3][pg & 7] = 1'b1;
         free_left = (bpa_pkg::RESERVED_PAGES > bpa_pkg::TOTAL_PAGES) ?
                     0 : bpa_pkg::TOTAL_PAGES - bpa_pkg::RESERVED_PAGES;
         predicted_results.delete();
      end else begin
         // Responses first: a request accepted at this edge cannot be answered at it.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_results.size() == 0) begin
               errors++;
               $display("%0t: response with nothing pending: status=%0d address=%h",
                        $time, rsp_ch.status, rsp_ch.page_address);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_ch.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_ch.status);
               end
               if (rsp_ch.page_address !== want.page_address) begin
                  errors++;
                  $display("%0t: page_address expected %h, got %h",
                           $time, want.page_address, rsp_ch.page_address);
               end
               if (rsp_ch.free_page_count !== want.free_count) begin
                  errors++;
                  $display("%0t: free_page_count expected %0d, got %0d",
                           $time, want.free_count, rsp_ch.free_page_count);
               end
               if (rsp_ch.used_page_count !== want.used_count) begin
                  errors++;
                  $display("%0t: used_page_count expected %0d, got %0d",
                           $time, want.used_count, rsp_ch.used_page_count);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            predicted_results.push_back(apply_request(req_ch.req_type, req_ch.free_address));
      end
      mismatch_count  <= errors;
      results_pending <= predicted_results.size();
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the bitmap page allocator.
// The top only generates requests, paces both channels and gives the verdict; the
// checker beside the block predicts every response and compares it field by field.
// The run goes through a short directed list, three random phases with different
// idling on each side, a long response stall that backs the block up, and a short
// random tail.
module tb;

   // A long response stall, in cycles, used to back the block up.
   localparam int LONG_HOLD    = 3000;
   localparam int PHASE_ITEMS  = 360;
   // Cycles of quiet after the last response; one full allocate scan plus margin.
   localparam int SETTLE_TIME  = 600;

   logic clock;
   logic reset;

   bpa_req_if req_ch ();
   bpa_rsp_if rsp_ch ();

   int mismatch_count;
   int results_pending;

   // Idling odds in percent per cycle, changed by the stimulus between phases.
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   logic hold_start;
   int   hold_left = 0;

   // Addresses handed out by the block, kept so that frees mostly hit pages in use.
   logic [bpa_pkg::ADDR_W-1:0] granted_pages [$];
   int                         oom_seen   = 0;
   int                         null_seen  = 0;
   int                         sent_count = 0;

   bitmap_page_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   page_allocator_checker page_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Response side. A pulse on hold_start keeps ready low while a countdown from LONG_HOLD
   // runs; otherwise ready is drawn each cycle against the current idling odds.
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_ch.ready <= (hold_left == 0) && !hold_start && ($urandom_range(99) >= rx_idle_pct);
   end

   // Watches response transfers to learn which pages are in use.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rsp_ch.status == bpa_pkg::STATUS_OOM) oom_seen <= oom_seen + 1;
         if (rsp_ch.status == bpa_pkg::STATUS_NULL) null_seen <= null_seen + 1;
         // Page zero comes back as address zero and cannot be freed by address, so it
         // is not kept.
         if (rsp_ch.status == bpa_pkg::STATUS_DONE && rsp_ch.page_address != '0)
            granted_pages.push_back(rsp_ch.page_address);
      end
   end

   // Offers one request, with random idle cycles first, and returns after its transfer.
   // Valid stays high on return so that back-to-back requests need no extra cycle.
   task automatic send_request(input logic kind, input logic [bpa_pkg::ADDR_W-1:0] addr);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.free_address <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   // Stops offering and waits until every predicted response has been taken.
   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // Mostly well-formed traffic: allocations, frees of pages the block handed out and
   // frees of reserved pages, with some frees of arbitrary and null addresses mixed in.
   task automatic random_request();
      int                         pick;
      int                         idx;
      logic [bpa_pkg::ADDR_W-1:0] addr;
      pick = $urandom_range(99);
      addr = bpa_pkg::ADDR_W'($urandom);
      if (pick < 45) begin
         // The address field is unused on allocate, so it carries noise.
         send_request(bpa_pkg::REQ_ALLOC, addr);
      end else if (pick < 75 && granted_pages.size() != 0) begin
         idx  = $urandom_range(granted_pages.size() - 1);
         addr = granted_pages[idx]
                | bpa_pkg::ADDR_W'($urandom_range(bpa_pkg::PAGE_BYTES - 1));
         granted_pages.delete(idx);
         send_request(bpa_pkg::REQ_FREE, addr);
      end else if (pick < 88) begin
         send_request(bpa_pkg::REQ_FREE, addr);
      end else if (pick < 95) begin
         addr = (bpa_pkg::ADDR_W'($urandom_range(bpa_pkg::RESERVED_PAGES - 1))
                 << bpa_pkg::PAGE_SHIFT)
                | bpa_pkg::ADDR_W'($urandom_range(bpa_pkg::PAGE_BYTES - 1));
         send_request(bpa_pkg::REQ_FREE, addr);
      end else begin
         send_request(bpa_pkg::REQ_FREE, '0);
      end
   endtask

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_idle_pct <= tx_pct;
      rx_idle_pct <= rx_pct;
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = bpa_pkg::REQ_ALLOC;
      req_ch.free_address = '0;
      hold_start          = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, sender idle often and receiver idle most of the time. The block
      // keeps input ready low while it writes the reset image, so the first transfer
      // simply waits for that.
      set_idling(35, 88);
      send_request(bpa_pkg::REQ_ALLOC, '0);         // first page above the reserved area
      send_request(bpa_pkg::REQ_ALLOC, '1);         // address noise on allocate
      send_request(bpa_pkg::REQ_FREE, '0);          // free of null is ignored
      send_request(bpa_pkg::REQ_FREE, 24'h000001);  // nonzero address inside page zero
      send_request(bpa_pkg::REQ_FREE, 24'h000FFF);  // same page again: double free
      send_request(bpa_pkg::REQ_ALLOC, '0);         // takes page zero back
      send_request(bpa_pkg::REQ_FREE, '1);          // top page, already free
      send_request(bpa_pkg::REQ_FREE, 24'h1FF800);  // last reserved page
      send_request(bpa_pkg::REQ_ALLOC, '0);         // refills the hole just made
      send_request(bpa_pkg::REQ_FREE, 24'h200000);  // first page above the reserved area
      send_request(bpa_pkg::REQ_FREE, 24'h201ABC);  // next one, offset bits set
      send_request(bpa_pkg::REQ_ALLOC, '0);
      send_request(bpa_pkg::REQ_ALLOC, '0);
      send_request(bpa_pkg::REQ_FREE, 24'h800000);  // free pages at single high bits
      send_request(bpa_pkg::REQ_FREE, 24'h400000);
      send_request(bpa_pkg::REQ_FREE, 24'h100000);  // a reserved page
      send_request(bpa_pkg::REQ_ALLOC, '0);
      send_request(bpa_pkg::REQ_FREE, 24'hAAAAAA);  // alternating bit patterns
      send_request(bpa_pkg::REQ_FREE, 24'h555555);
      send_request(bpa_pkg::REQ_ALLOC, 24'h555555);

      repeat (PHASE_ITEMS) random_request();

      // The sender pauses here until every response is back.
      wait_until_drained();

      // Sender idle most of the time, receiver idle often.
      set_idling(88, 35);
      repeat (PHASE_ITEMS) random_request();

      // Long response stall while requests keep coming: the output register fills, the
      // next request finishes behind it and input ready drops until the stall ends.
      set_idling(0, 0);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      repeat (24) random_request();

      // No idling on either side.
      repeat (PHASE_ITEMS - 24) random_request();

      // Short random tail with the first idling mix again.
      set_idling(35, 88);
      repeat (40) random_request();

      set_idling(0, 0);
      wait_until_drained();
      repeat (SETTLE_TIME) @(posedge clock);

      $display("Sent %0d requests: directed corner cases, three idling mixes and a long",
               sent_count);
      $display("response stall (%0d out of memory, %0d null frees).",
               oom_seen, null_seen);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #(50_000_000);
      $display("Timed out at %0t with %0d responses outstanding", $time, results_pending);
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_channels.sv
rtl/bpa_ram.sv
rtl/bitmap_page_allocator.sv
rtl/bpa_checker.sv
dv/page_allocator_checker.sv
dv/tb.sv
